// ----- rtl/acot_pkg.sv -----
package acot_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int SERIES_TERMS  = 11;
    localparam int INT_FRAC      = 31;

    localparam int DATA_W  = 32;
    localparam int QUO_W   = 32;
    localparam int ACC_W   = 34;
    localparam int ANG_W   = ACC_W + 1;
    localparam int ANGLE_W = 17;
    localparam int RND_SH  = INT_FRAC - FRACTION_BITS;

    localparam logic [DATA_W-1:0] PI_HALF_Q31 = 32'hC90FDAA2;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX =
        ANGLE_W'((33'(PI_HALF_Q31) + (33'd1 << (RND_SH - 1))) >> RND_SH);

    typedef struct packed {
        logic vld;
        logic neg;
        logic below_one;
    } t_tag;

endpackage

// ----- rtl/acot_recip.sv -----
module acot_recip (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [acot_pkg::DATA_W-1:0]    i_den,
    input  acot_pkg::t_tag                 i_tag,
    output logic [acot_pkg::DATA_W-1:0]    o_den,
    output logic [acot_pkg::QUO_W-1:0]     o_quo,
    output acot_pkg::t_tag                 o_tag
);

    localparam int N  = acot_pkg::QUO_W;
    localparam int DW = acot_pkg::DATA_W;

    logic [DW-1:0]          r_den [0:N-1];
    logic [DW-1:0]          r_rem [0:N-1];
    logic [N-1:0]           r_quo [0:N-1];
    acot_pkg::t_tag         r_tag [0:N-1];

    // One quotient bit per stage of 2^(31+FRACTION_BITS) / den, MSB first
    for (genvar j = 0; j < N; j++) begin : g_bit
        logic [DW-1:0]  w_den;
        logic [DW-1:0]  w_rem;
        logic [N-1:0]   w_quo;
        acot_pkg::t_tag w_tag;
        logic [DW:0]    n_shift;
        logic           n_take;

        if (j == 0) begin : g_first
            assign w_den = i_den;
            assign w_rem = DW'(1) << (acot_pkg::FRACTION_BITS - 1);
            assign w_quo = '0;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_den = r_den[j-1];
            assign w_rem = r_rem[j-1];
            assign w_quo = r_quo[j-1];
            assign w_tag = r_tag[j-1];
        end

        always_comb begin
            n_shift = {w_rem, 1'b0};
            n_take  = n_shift >= {1'b0, w_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[j] <= w_tag;
                r_den[j] <= w_den;
                r_rem[j] <= n_take ? DW'(n_shift - {1'b0, w_den}) : n_shift[DW-1:0];
                r_quo[j] <= {w_quo[N-2:0], n_take};
            end
        end
    end

    assign o_den = r_den[N-1];
    assign o_quo = r_quo[N-1];
    assign o_tag = r_tag[N-1];

endmodule

// ----- rtl/acot_series.sv -----
module acot_series (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [acot_pkg::DATA_W-1:0]         i_v,
    input  acot_pkg::t_tag                      i_tag,
    output logic signed [acot_pkg::ACC_W-1:0]   o_acc,
    output acot_pkg::t_tag                      o_tag
);

    localparam int T  = acot_pkg::SERIES_TERMS;
    localparam int DW = acot_pkg::DATA_W;
    localparam int AW = acot_pkg::ACC_W;
    localparam int FR = acot_pkg::INT_FRAC;

    logic [2*DW-1:0]        n_sq;
    logic [DW-1:0]          r_p_pw;
    logic [DW-1:0]          r_p_v2;
    acot_pkg::t_tag         r_p_tag;

    logic [2*DW-1:0]        r_a_pp  [0:T-2];
    logic [2*DW-1:0]        r_a_pd  [0:T-1];
    logic [DW-1:0]          r_a_pw  [0:T-1];
    logic [DW-1:0]          r_a_v2  [0:T-2];
    logic signed [AW-1:0]   r_a_acc [0:T-1];
    acot_pkg::t_tag         r_a_tag [0:T-1];

    logic [DW-1:0]          r_b_pw  [0:T-2];
    logic [DW-1:0]          r_b_v2  [0:T-2];
    logic signed [AW-1:0]   r_b_acc [0:T-1];
    acot_pkg::t_tag         r_b_tag [0:T-1];

    assign n_sq = 64'(i_v) * 64'(i_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_p_tag <= i_tag;
            r_p_pw  <= i_v;
            r_p_v2  <= n_sq[FR+DW-1:FR];
        end
    end

    // Two stages per term: multiply, then fix up the quotient and accumulate
    for (genvar i = 0; i < T; i++) begin : g_term
        localparam int unsigned    K = 2 * i + 1;
        localparam logic [DW:0]    M = (DW+1)'((65'd1 << DW) / K);

        logic [DW-1:0]          w_pw;
        logic [DW-1:0]          w_v2;
        logic signed [AW-1:0]   w_acc;
        acot_pkg::t_tag         w_tag;
        logic [DW-1:0]          n_qe;
        logic [DW-1:0]          n_qk;
        logic [DW-1:0]          n_rem;
        logic [DW-1:0]          n_q;
        logic signed [AW-1:0]   n_acc;

        if (i == 0) begin : g_first
            assign w_pw  = r_p_pw;
            assign w_v2  = r_p_v2;
            assign w_acc = '0;
            assign w_tag = r_p_tag;
        end else begin : g_next
            assign w_pw  = r_b_pw[i-1];
            assign w_v2  = r_b_v2[i-1];
            assign w_acc = r_b_acc[i-1];
            assign w_tag = r_b_tag[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_tag[i].vld <= 1'b0;
            end else if (i_en) begin
                r_a_tag[i] <= w_tag;
                r_a_pw[i]  <= w_pw;
                r_a_acc[i] <= w_acc;
                r_a_pd[i]  <= 64'(w_pw) * 64'(M);
            end
        end

        // estimate is at most one short of the true quotient
        always_comb begin
            n_qe  = r_a_pd[i][2*DW-1:DW];
            n_qk  = DW'(64'(n_qe) * 64'(K));
            n_rem = r_a_pw[i] - n_qk;
            n_q   = (n_rem >= DW'(K)) ? n_qe + DW'(1) : n_qe;
            if ((i % 2) == 0) begin
                n_acc = r_a_acc[i] + $signed(AW'(n_q));
            end else begin
                n_acc = r_a_acc[i] - $signed(AW'(n_q));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_tag[i].vld <= 1'b0;
            end else if (i_en) begin
                r_b_tag[i] <= r_a_tag[i];
                r_b_acc[i] <= n_acc;
            end
        end

        if (i < T - 1) begin : g_pow
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a_v2[i] <= w_v2;
                    r_a_pp[i] <= 64'(w_pw) * 64'(w_v2);
                    r_b_v2[i] <= r_a_v2[i];
                    r_b_pw[i] <= r_a_pp[i][FR+DW-1:FR];
                end
            end
        end
    end

    assign o_acc = r_b_acc[T-1];
    assign o_tag = r_b_tag[T-1];

endmodule

// ----- rtl/arccot_taylor_series_unit.sv -----
// Arccotangent of a signed Q16.16 argument, returned as unsigned Q1.16 radians.
// Input channel: i_s_tvalid / o_s_tready / i_s_tdata carry x (32 bits).
// Output channel: o_m_tvalid / i_m_tready / o_m_tdata carry the angle, o_m_tuser
// the valid flag (1 for x >= 0). A negative x yields angle 0 with flag 0.
// For x >= 1 the argument is first inverted by a restoring divider, one
// quotient bit per stage (32 stages). The series then runs one stage to
// square the argument and two stages per term (11 terms), then one output
// stage clamps to 0..pi/2 and rounds.
// Throughput: one transaction per cycle while the output channel is not stalled.
// The whole pipeline advances together; a stall on i_m_tready holds every
// stage and drops o_s_tready in the same cycle, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; the output
// channel is idle in the cycle after reset.
module arccot_taylor_series_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] x_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [16:0] angle, [23:17] zero
    output logic [0:0]  o_m_tuser    // [0] valid_res
);

    localparam int DW = acot_pkg::DATA_W;
    localparam int AW = acot_pkg::ACC_W;
    localparam int GW = acot_pkg::ANG_W;
    localparam int SH = acot_pkg::RND_SH;

    logic                           w_en;
    acot_pkg::t_tag                 w_in_tag;
    logic [DW-1:0]                  w_den;
    logic [acot_pkg::QUO_W-1:0]     w_quo;
    acot_pkg::t_tag                 w_div_tag;
    logic [DW-1:0]                  r_v;
    acot_pkg::t_tag                 r_v_tag;
    logic signed [AW-1:0]           w_acc;
    acot_pkg::t_tag                 w_ser_tag;

    logic signed [GW-1:0]           w_pi;
    logic signed [GW-1:0]           w_ang;
    logic [DW-1:0]                  w_clamp;
    logic [DW:0]                    w_rnd;

    logic                           r_out_vld;
    logic [acot_pkg::ANGLE_W-1:0]   r_angle;
    logic                           r_valid_res;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    assign w_in_tag.vld       = i_s_tvalid;
    assign w_in_tag.neg       = i_s_tdata[DW-1];
    assign w_in_tag.below_one = i_s_tdata < (DW'(1) << acot_pkg::FRACTION_BITS);

    acot_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_den   (i_s_tdata),
        .i_tag   (w_in_tag),
        .o_den   (w_den),
        .o_quo   (w_quo),
        .o_tag   (w_div_tag)
    );

    // below one the argument is used directly, otherwise its reciprocal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_v_tag <= w_div_tag;
            r_v     <= w_div_tag.below_one ? DW'(w_den << SH) : DW'(w_quo);
        end
    end

    acot_series u_series (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (r_v),
        .i_tag   (r_v_tag),
        .o_acc   (w_acc),
        .o_tag   (w_ser_tag)
    );

    always_comb begin
        w_pi  = $signed(GW'(acot_pkg::PI_HALF_Q31));
        w_ang = w_ser_tag.below_one ? w_pi - GW'(w_acc) : GW'(w_acc);
        priority if (w_ang < 0) begin
            w_clamp = '0;
        end else if (w_ang > w_pi) begin
            w_clamp = acot_pkg::PI_HALF_Q31;
        end else begin
            w_clamp = DW'(w_ang);
        end
        w_rnd = (DW+1)'((33'(w_clamp) + (33'd1 << (SH - 1))) >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld   <= w_ser_tag.vld;
            r_valid_res <= !w_ser_tag.neg;
            r_angle     <= w_ser_tag.neg ? '0 : w_rnd[acot_pkg::ANGLE_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(24 - acot_pkg::ANGLE_W)'(0), r_angle};
    assign o_m_tuser  = r_valid_res;

    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("invalid result carries a non-zero angle");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[acot_pkg::ANGLE_W-1:0] <= acot_pkg::ANGLE_MAX))
        else $error("angle above pi/2");

    a_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule
